>>> src/swm_pkg.sv
// Shared constants for the sliding-window median unit.
package swm_pkg;

	// Fixed widths of the port words.
	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 11;

	// Default build of the count tree and the delay line.
	localparam int VALUE_BITS_DEF = 16;
	localparam int WINDOW_MAX_DEF = 1024;

	// Window length after reset.
	localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(1);

endpackage

>>> src/sliding_window_median_unit.sv
// Sliding-window median unit: count tree, delay line and the sequencer that walks them.
// An accepted sample word yields its median word once the window is full; the count-tree memory has one
// read port and one write port, so all steps are serial. A new sample word is taken only after the
// last one is through: while filling there is no removal, and no descent until the window fills;
// an untaken median word holds the next one in the output step. Reset clears control
// state, sets window_size to 1 and clears the tree, as does a write.
module sliding_window_median_unit #(
	parameter int VALUE_BITS = swm_pkg::VALUE_BITS_DEF,
	parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [swm_pkg::CFG_W-1:0]    window_size,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [swm_pkg::SAMPLE_W-1:0] sample,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [swm_pkg::SAMPLE_W-1:0] median
);

	localparam int NODE_W   = VALUE_BITS + 1;
	localparam int NODES    = 1 << NODE_W;
	localparam int K_W      = $clog2(WINDOW_MAX + 1);
	localparam int PTR_W    = $clog2(WINDOW_MAX);
	localparam int LVL_W    = $clog2(VALUE_BITS + 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HIST  = 3'd2;
	localparam logic [2:0] S_REM   = 3'd3;
	localparam logic [2:0] S_ADD   = 3'd4;
	localparam logic [2:0] S_DESC  = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]                  state_q;
	logic [swm_pkg::CFG_W-1:0]   window_q;
	logic [NODE_W-1:0]           clr_q;
	logic [PTR_W-1:0]            wp_q;
	logic [K_W-1:0]              fill_q;
	logic [VALUE_BITS-1:0]       sample_q;
	logic [NODE_W-1:0]           node_q;
	logic [NODE_W-1:0]           wnode_q;
	logic                        pend_q;
	logic                        emit_q;
	logic [K_W-1:0]              rank_q;
	logic [LVL_W-1:0]            level_q;
	logic                        ph_q;
	logic                        out_valid_q;
	logic [swm_pkg::SAMPLE_W-1:0] median_q;

	logic [K_W-1:0]              tree_mem [NODES];
	logic [K_W-1:0]              tree_rd_q;
	logic [VALUE_BITS-1:0]       hist_mem [WINDOW_MAX];
	logic [VALUE_BITS-1:0]       hist_rd_q;

	logic [31:0]                 k_wide;
	logic [K_W-1:0]              k_eff;
	logic [K_W-1:0]              rank_init;
	logic [K_W:0]                wp_inc;
	logic [PTR_W-1:0]            wp_next;
	logic [K_W:0]                fill_inc;
	logic                        go_left;
	logic [NODE_W-1:0]           n_next;
	logic [K_W-1:0]              rank_next;
	logic [NODE_W-1:0]           tree_ra;
	logic                        tree_we;
	logic [NODE_W-1:0]           tree_wa;
	logic [K_W-1:0]              tree_wd;
	logic                        hist_we;
	logic                        in_acc;
	logic                        out_load;

	// Effective window length: zero counts as one, large values saturate.
	always_comb begin
		k_wide = 32'(window_q);
		if (window_q == '0) begin
			k_wide = 32'd1;
		end else if (32'(window_q) > 32'(WINDOW_MAX)) begin
			k_wide = 32'(WINDOW_MAX);
		end
		k_eff     = K_W'(k_wide);
		rank_init = K_W'(((K_W + 1)'(k_eff) + (K_W + 1)'(1)) >> 1);
	end

	// Write pointer wraps at the window length; fill count steps toward it.
	assign wp_inc   = (K_W + 1)'(wp_q) + (K_W + 1)'(1);
	assign wp_next  = (wp_inc >= (K_W + 1)'(k_eff)) ? '0 : PTR_W'(wp_inc);
	assign fill_inc = (K_W + 1)'(fill_q) + (K_W + 1)'(1);

	// One descent decision: the left child's count against the remaining rank.
	assign go_left   = tree_rd_q >= rank_q;
	assign n_next    = {node_q[NODE_W-2:0], ~go_left};
	assign rank_next = go_left ? rank_q : rank_q - tree_rd_q;

	// Count-tree port control: clearing pass, read-modify-write walks and descent reads.
	always_comb begin
		tree_ra = node_q;
		tree_we = 1'b0;
		tree_wa = wnode_q;
		tree_wd = tree_rd_q;
		unique case (state_q)
			S_CLEAR: begin
				tree_we = 1'b1;
				tree_wa = clr_q;
				tree_wd = '0;
			end
			S_REM: begin
				tree_we = pend_q;
				tree_wd = tree_rd_q - K_W'(1);
			end
			S_ADD: begin
				tree_we = pend_q;
				tree_wd = tree_rd_q + K_W'(1);
			end
			S_DESC: begin
				tree_ra = ph_q ? {n_next[NODE_W-2:0], 1'b0} : {node_q[NODE_W-2:0], 1'b0};
			end
			default: begin
				tree_ra = node_q;
			end
		endcase
	end

	// Count-tree memory with a registered read port.
	always_ff @(posedge clk) begin
		if (tree_we) begin
			tree_mem[tree_wa] <= tree_wd;
		end
		tree_rd_q <= tree_mem[tree_ra];
	end

	// Delay line of the window; the oldest sample sits at the write pointer.
	assign hist_we = (state_q == S_HIST);
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[wp_q] <= sample_q;
		end
		hist_rd_q <= hist_mem[wp_q];
	end

	// A window word takes precedence, so no sample word is taken in the same cycle.
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign median    = median_q;

	// The output register takes a new median word once the previous one is gone.
	assign out_load = (state_q == S_OUT) && !cfg_valid && (!out_valid_q || out_ready);

	// Sequencer: add the new sample; when full, also remove the oldest and find the median.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			window_q    <= swm_pkg::WINDOW_RESET;
			clr_q       <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			pend_q      <= 1'b0;
			emit_q      <= 1'b0;
			ph_q        <= 1'b0;
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				median_q    <= swm_pkg::SAMPLE_W'(node_q[VALUE_BITS-1:0]);
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				window_q <= window_size;
				state_q  <= S_CLEAR;
				clr_q    <= '0;
				wp_q     <= '0;
				fill_q   <= '0;
			end else begin
				unique case (state_q)
					S_CLEAR: begin
						clr_q <= clr_q + NODE_W'(1);
						if (clr_q == '1) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (in_acc) begin
							sample_q <= sample[VALUE_BITS-1:0];
							state_q  <= S_HIST;
						end
					end
					S_HIST: begin
						wp_q   <= wp_next;
						pend_q <= 1'b0;
						if (fill_q >= k_eff) begin
							emit_q  <= 1'b1;
							node_q  <= {1'b1, hist_rd_q};
							state_q <= S_REM;
						end else begin
							emit_q  <= (fill_inc == (K_W + 1)'(k_eff));
							fill_q  <= K_W'(fill_inc);
							node_q  <= {1'b1, sample_q};
							state_q <= S_ADD;
						end
					end
					S_REM, S_ADD: begin
						wnode_q <= node_q;
						if (node_q == '0) begin
							pend_q <= 1'b0;
							if (state_q == S_REM) begin
								node_q  <= {1'b1, sample_q};
								state_q <= S_ADD;
							end else if (emit_q) begin
								node_q  <= NODE_W'(1);
								rank_q  <= rank_init;
								level_q <= '0;
								ph_q    <= 1'b0;
								state_q <= S_DESC;
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							pend_q <= 1'b1;
							node_q <= node_q >> 1;
						end
					end
					S_DESC: begin
						if (!ph_q) begin
							ph_q <= 1'b1;
						end else begin
							node_q  <= n_next;
							rank_q  <= rank_next;
							level_q <= level_q + LVL_W'(1);
							if (level_q == LVL_W'(VALUE_BITS - 1)) begin
								state_q <= S_OUT;
							end
						end
					end
					S_OUT: begin
						if (out_load) begin
							state_q <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	// A median word only appears at the end of a descent.
	a_out_from_descent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("median word raised outside the output step");

	// The fill count never passes the window length.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= k_eff)
		else $error("fill count beyond window length");

	// The write pointer stays inside the window.
	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(K_W + 1)'(wp_q) < (K_W + 1)'(k_eff))
		else $error("write pointer outside window");

	// An accepted sample word starts with the delay-line step.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !cfg_valid) |=> (state_q == S_HIST))
		else $error("accepted word did not start processing");

endmodule
